/* design/rgbww_slew_limited_dimmer_defines.svh */
// Assertion helpers shared by the dimmer RTL.
// Every property is clocked on clk and held off while rst_n is low.
`ifndef RGBWW_SLEW_LIMITED_DIMMER_DEFINES_SVH
`define RGBWW_SLEW_LIMITED_DIMMER_DEFINES_SVH

// Same-cycle implication.
`define RGBWW_SLD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RGBWW_SLD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rgbww_sld_pkg.sv */
`timescale 1ns / 1ps

package rgbww_sld_pkg;

    localparam int DUTY_W  = 10;
    localparam int LEVEL_W = 10;
    localparam int CT_W    = 9;
    localparam int COLOR_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int PROD_W  = 18;
    localparam int RECIP_W = 19;
    localparam int WIDE_W  = PROD_W + RECIP_W;
    localparam int RECIP_SH = 26;

    localparam logic [DUTY_W-1:0] FADE_STEP = 10'd25;

    localparam logic [CT_W-1:0] CT_MIN = 9'd154;
    localparam logic [CT_W-1:0] CT_MID = 9'd327;
    localparam logic [CT_W-1:0] CT_MAX = 9'd500;

    localparam logic [LEVEL_W-1:0] RGB_LEVEL_RST = 10'd1023;

    // ceil(2^26 / 173) and ceil(2^26 / 255); exact floor division for
    // every 18-bit product this block can form.
    localparam logic [RECIP_W-1:0] RECIP_173 = 19'd387913;
    localparam logic [RECIP_W-1:0] RECIP_255 = 19'd263173;

    localparam logic [CFG_IDX_W-1:0] REG_WHITE_ON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_TEMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RGB_ON      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RGB_LEVEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RED         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE        = 3'd7;

    typedef logic [DUTY_W-1:0] duty_t;

    // Floor division of a product by a constant through its reciprocal.
    function automatic duty_t recip_div(input logic [PROD_W-1:0] x,
                                        input logic [RECIP_W-1:0] recip);
        logic [WIDE_W-1:0] p;
        begin
            p = {{RECIP_W{1'b0}}, x} * {{PROD_W{1'b0}}, recip};
            return p[RECIP_SH +: DUTY_W];
        end
    endfunction

    // Move one step toward the target, snap once within a step.
    function automatic duty_t slew_step(input duty_t now, input duty_t tgt);
        logic [DUTY_W:0] up;
        logic [DUTY_W:0] lim;
        begin
            up  = {1'b0, now} + {1'b0, FADE_STEP};
            lim = {1'b0, tgt} + {1'b0, FADE_STEP};
            if (up < {1'b0, tgt})
                return up[DUTY_W-1:0];
            else if ({1'b0, now} > lim)
                return now - FADE_STEP;
            else
                return tgt;
        end
    endfunction

    function automatic logic within_step(input duty_t a, input duty_t b);
        begin
            return (a > b) ? ((a - b) <= FADE_STEP) : ((b - a) <= FADE_STEP);
        end
    endfunction

endpackage

/* design/rgbww_slew_limited_dimmer.sv */
`timescale 1ns / 1ps
`include "rgbww_slew_limited_dimmer_defines.svh"

// Five-channel slew-limited dimmer (red, green, blue, warm, cold). Each input
// beat carries a tick bit; each beat yields exactly one output beat with the
// five 10-bit duties as they stand after that beat. A tick of 1 moves every
// duty 25 counts toward its target (snapping once within 25); a tick of 0
// only reports. One beat is accepted per clock cycle unless back-pressure on
// m_tready fills the stages; the rate is set by the update loop on the duty
// registers. An accepted beat passes two input stages, then the duty update
// into the output register. Targets are derived from the configuration
// registers by a free-running two-stage pipeline (products, then reciprocal
// division), so a write is seen by every beat accepted in a later cycle.
// Color temperature is clamped to 154..500 mireds; the user must make writes
// only while no beat is in flight, and the block itself does not enforce this.
module rgbww_slew_limited_dimmer
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // config write port
    input  logic                                  cfg_we,
    input  logic [rgbww_sld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgbww_sld_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,  // [0] tick, [7:1] zero
    // output stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [9:0] red_duty, [19:10] green_duty, [29:20] blue_duty,
    // [39:30] warm_duty, [49:40] cold_duty, [55:50] zero
    output logic [55:0]                           m_tdata
);
    import rgbww_sld_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic                white_on_reg;
    logic [LEVEL_W-1:0]  white_level_reg;
    logic [CT_W-1:0]     color_temp_reg;
    logic                rgb_on_reg;
    logic [LEVEL_W-1:0]  rgb_level_reg;
    logic [COLOR_W-1:0]  red_value_reg;
    logic [COLOR_W-1:0]  green_value_reg;
    logic [COLOR_W-1:0]  blue_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_on_reg    <= 1'b0;
            white_level_reg <= '0;
            color_temp_reg  <= CT_MID;
            rgb_on_reg      <= 1'b0;
            rgb_level_reg   <= RGB_LEVEL_RST;
            red_value_reg   <= '0;
            green_value_reg <= '0;
            blue_value_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WHITE_ON:    white_on_reg    <= cfg_data[0];
                REG_WHITE_LEVEL: white_level_reg <= cfg_data[LEVEL_W-1:0];
                REG_COLOR_TEMP:  color_temp_reg  <= cfg_data[CT_W-1:0];
                REG_RGB_ON:      rgb_on_reg      <= cfg_data[0];
                REG_RGB_LEVEL:   rgb_level_reg   <= cfg_data[LEVEL_W-1:0];
                REG_RED:         red_value_reg   <= cfg_data[COLOR_W-1:0];
                REG_GREEN:       green_value_reg <= cfg_data[COLOR_W-1:0];
                REG_BLUE:        blue_value_reg  <= cfg_data[COLOR_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Target pipeline, stage A: clamp the color temperature and form
    // the products. At or below the midpoint warm takes the full level
    // and cold is scaled by (ct-154); at the midpoint that scale is 173,
    // which gives the full level too. Above it the roles swap.
    // ---------------------------------------------------------------
    logic [CT_W-1:0]     ct_clamp;
    logic                warm_full_next;
    logic [COLOR_W-1:0]  ct_scale;
    logic [PROD_W-1:0]   white_prod_next;
    logic [PROD_W-1:0]   red_prod_next;
    logic [PROD_W-1:0]   green_prod_next;
    logic [PROD_W-1:0]   blue_prod_next;

    always_comb
    begin
        if (color_temp_reg < CT_MIN)
            ct_clamp = CT_MIN;
        else if (color_temp_reg > CT_MAX)
            ct_clamp = CT_MAX;
        else
            ct_clamp = color_temp_reg;
        warm_full_next = (ct_clamp <= CT_MID);
        if (warm_full_next)
            ct_scale = COLOR_W'(ct_clamp - CT_MIN);
        else
            ct_scale = COLOR_W'(CT_MAX - ct_clamp);
        white_prod_next = PROD_W'(ct_scale) * PROD_W'(white_level_reg);
        red_prod_next   = PROD_W'(red_value_reg) * PROD_W'(rgb_level_reg);
        green_prod_next = PROD_W'(green_value_reg) * PROD_W'(rgb_level_reg);
        blue_prod_next  = PROD_W'(blue_value_reg) * PROD_W'(rgb_level_reg);
    end

    logic                white_on_a_reg;
    logic                rgb_on_a_reg;
    logic                warm_full_reg;
    logic [LEVEL_W-1:0]  white_level_a_reg;
    logic [PROD_W-1:0]   white_prod_reg;
    logic [PROD_W-1:0]   red_prod_reg;
    logic [PROD_W-1:0]   green_prod_reg;
    logic [PROD_W-1:0]   blue_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_on_a_reg <= 1'b0;
            rgb_on_a_reg   <= 1'b0;
        end
        else
        begin
            white_on_a_reg <= white_on_reg;
            rgb_on_a_reg   <= rgb_on_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        warm_full_reg     <= warm_full_next;
        white_level_a_reg <= white_level_reg;
        white_prod_reg    <= white_prod_next;
        red_prod_reg      <= red_prod_next;
        green_prod_reg    <= green_prod_next;
        blue_prod_reg     <= blue_prod_next;
    end

    // ---------------------------------------------------------------
    // Target pipeline, stage B: divide by the reciprocal, gate by the
    // on flags.
    // ---------------------------------------------------------------
    duty_t white_scaled;
    duty_t red_tgt_next;
    duty_t green_tgt_next;
    duty_t blue_tgt_next;
    duty_t warm_tgt_next;
    duty_t cold_tgt_next;

    always_comb
    begin
        white_scaled   = recip_div(white_prod_reg, RECIP_173);
        red_tgt_next   = rgb_on_a_reg ? recip_div(red_prod_reg, RECIP_255) : '0;
        green_tgt_next = rgb_on_a_reg ? recip_div(green_prod_reg, RECIP_255) : '0;
        blue_tgt_next  = rgb_on_a_reg ? recip_div(blue_prod_reg, RECIP_255) : '0;
        if (!white_on_a_reg)
        begin
            warm_tgt_next = '0;
            cold_tgt_next = '0;
        end
        else if (warm_full_reg)
        begin
            warm_tgt_next = white_level_a_reg;
            cold_tgt_next = white_scaled;
        end
        else
        begin
            warm_tgt_next = white_scaled;
            cold_tgt_next = white_level_a_reg;
        end
    end

    duty_t red_tgt_reg;
    duty_t green_tgt_reg;
    duty_t blue_tgt_reg;
    duty_t warm_tgt_reg;
    duty_t cold_tgt_reg;

    always_ff @(posedge clk)
    begin
        red_tgt_reg   <= red_tgt_next;
        green_tgt_reg <= green_tgt_next;
        blue_tgt_reg  <= blue_tgt_next;
        warm_tgt_reg  <= warm_tgt_next;
        cold_tgt_reg  <= cold_tgt_next;
    end

    // ---------------------------------------------------------------
    // Beat path: two input stages, then the duty update. Each stage
    // loads when it is empty or its contents move on, so input beats can
    // still fill empty stages while a result waits at the output.
    // ---------------------------------------------------------------
    logic v1_reg;
    logic tick1_reg;
    logic v2_reg;
    logic tick2_reg;
    logic out_valid_reg;
    logic out_ready;
    logic st2_ready;
    logic st1_ready;
    logic update;

    assign out_ready = !out_valid_reg || m_tready;
    assign st2_ready = !v2_reg || out_ready;
    assign st1_ready = !v1_reg || st2_ready;
    assign update    = v2_reg && out_ready;
    assign s_tready  = st1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (st1_ready)
                v1_reg <= s_tvalid;
            if (st2_ready)
                v2_reg <= v1_reg;
            if (out_ready)
                out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // hold the tick with its beat
        if (s_tvalid && st1_ready)
            tick1_reg <= s_tdata[0];
        if (v1_reg && st2_ready)
            tick2_reg <= tick1_reg;
    end

    // ---------------------------------------------------------------
    // Duty state; it doubles as the output data register, since a
    // result is the state right after its beat.
    // ---------------------------------------------------------------
    duty_t red_now_reg;
    duty_t green_now_reg;
    duty_t blue_now_reg;
    duty_t warm_now_reg;
    duty_t cold_now_reg;
    duty_t red_now_next;
    duty_t green_now_next;
    duty_t blue_now_next;
    duty_t warm_now_next;
    duty_t cold_now_next;

    always_comb
    begin
        red_now_next   = slew_step(red_now_reg, red_tgt_reg);
        green_now_next = slew_step(green_now_reg, green_tgt_reg);
        blue_now_next  = slew_step(blue_now_reg, blue_tgt_reg);
        warm_now_next  = slew_step(warm_now_reg, warm_tgt_reg);
        cold_now_next  = slew_step(cold_now_reg, cold_tgt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_now_reg   <= '0;
            green_now_reg <= '0;
            blue_now_reg  <= '0;
            warm_now_reg  <= '0;
            cold_now_reg  <= '0;
        end
        else if (update && tick2_reg)
        begin
            red_now_reg   <= red_now_next;
            green_now_reg <= green_now_next;
            blue_now_reg  <= blue_now_next;
            warm_now_reg  <= warm_now_next;
            cold_now_reg  <= cold_now_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, cold_now_reg, warm_now_reg, blue_now_reg,
                       green_now_reg, red_now_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic steps_ok;

    assign steps_ok = within_step(red_now_reg, red_now_next)
                   && within_step(green_now_reg, green_now_next)
                   && within_step(blue_now_reg, blue_now_next)
                   && within_step(warm_now_reg, warm_now_next)
                   && within_step(cold_now_reg, cold_now_next);

    `RGBWW_SLD_ASSERT_IMP(a_slew_bounded, update && tick2_reg, steps_ok, "duty moved more than one step")
    `RGBWW_SLD_ASSERT_NXT(a_idle_tick_holds, update && !tick2_reg, $stable(m_tdata), "duty changed on a zero tick")
    `RGBWW_SLD_ASSERT_IMP(a_full_pipe_stalls, v1_reg && v2_reg && out_valid_reg && !m_tready, !s_tready, "input taken into a full pipeline")
    `RGBWW_SLD_ASSERT_NXT(a_white_off_zero, !white_on_a_reg, warm_tgt_reg == '0 && cold_tgt_reg == '0, "white target nonzero while white is off")

endmodule
